// ===== sv/fsp_pkg.sv =====
`default_nettype none

package fsp_pkg;

    // field and datapath widths
    localparam int DATA_W   = 16;
    localparam int INOW_W   = 8;
    localparam int ACC_W    = 17;   // error and pre-clamp integral, never wrap
    localparam int PROD_W   = 33;   // 16 x 17 signed product
    localparam int SUM_W    = 34;
    localparam int DRV_W    = SUM_W - 8;
    localparam int FSUM_W   = 19;   // 3*old + 2*measured - remainder
    localparam int FMAG_W   = 18;

    localparam int DEADBAND = 6;

    // truncating divide by five: q = (x * DIV5_MUL) >> DIV5_SHIFT, exact for x < 2^19
    localparam int              DIV5_SHIFT = 21;
    localparam int              DIV5_MUL_W = 19;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 19'd419431;
    localparam int              DIV5_PROD_W = FMAG_W + DIV5_MUL_W;

    // configuration register indexes
    localparam int         CFG_IDX_W   = 2;
    localparam logic [1:0] REG_KP      = 2'd0;
    localparam logic [1:0] REG_KI      = 2'd1;
    localparam logic [1:0] REG_OUT_MAX = 2'd2;
    localparam logic [1:0] REG_OUT_MIN = 2'd3;

    // beat after the filter stage
    typedef struct packed {
        logic signed [DATA_W-1:0] speed;
        logic signed [DATA_W-1:0] target;
    } filt_beat_t;

    // beat after the integral stage
    typedef struct packed {
        logic signed [ACC_W-1:0]  err;
        logic signed [ACC_W-1:0]  integ;
        logic signed [DATA_W-1:0] speed;
        logic        [INOW_W-1:0] integ_now;
    } integ_beat_t;

    // beat after the product stage
    typedef struct packed {
        logic signed [PROD_W-1:0] prod_p;
        logic signed [PROD_W-1:0] prod_i;
        logic signed [DATA_W-1:0] speed;
        logic        [INOW_W-1:0] integ_now;
    } prod_beat_t;

    // result beat
    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] speed;
        logic        [INOW_W-1:0] integ_now;
    } out_beat_t;

    // x mod 5 for a 16-bit magnitude; 16 is 1 mod 5 so nibbles just add
    function automatic logic [2:0] mod5_u16(input logic [DATA_W-1:0] x);
        logic [5:0] s1;
        logic [4:0] s2;
        s1 = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]);
        s2 = 5'(s1[3:0]) + 5'(s1[5:4]);
        if (s2 >= 5'd10) begin
            s2 = s2 - 5'd10;
        end
        if (s2 >= 5'd5) begin
            s2 = s2 - 5'd5;
        end
        return s2[2:0];
    endfunction

    // trunc((5*trunc(3*old/5) + 2*meas) / 5), with 5*trunc(3*old/5) = 3*old - rem
    function automatic logic signed [DATA_W-1:0] filter_next(
        input logic signed [DATA_W-1:0] old,
        input logic signed [DATA_W-1:0] meas
    );
        logic [DATA_W-1:0]        old_mag;
        logic [2:0]               m5;
        logic [2:0]               rem_mag;
        logic signed [FSUM_W-1:0] s;
        logic [FMAG_W-1:0]        s_mag;
        logic [DIV5_PROD_W-1:0]   prod;
        logic [DATA_W-1:0]        q_mag;
        old_mag = old[DATA_W-1] ? (~old + 16'd1) : old;
        m5 = mod5_u16(old_mag);
        // remainder of 3*|old| by 5
        case (m5)
            3'd0:    rem_mag = 3'd0;
            3'd1:    rem_mag = 3'd3;
            3'd2:    rem_mag = 3'd1;
            3'd3:    rem_mag = 3'd4;
            3'd4:    rem_mag = 3'd2;
            default: rem_mag = 3'd0;
        endcase
        s = (FSUM_W'(old) <<< 1) + FSUM_W'(old) + (FSUM_W'(meas) <<< 1);
        if (old[DATA_W-1]) begin
            s = s + $signed({16'd0, rem_mag});
        end else begin
            s = s - $signed({16'd0, rem_mag});
        end
        s_mag = s[FSUM_W-1] ? FMAG_W'(-s) : FMAG_W'(s);
        prod  = DIV5_PROD_W'(s_mag) * DIV5_PROD_W'(DIV5_MUL);
        q_mag = DATA_W'(prod >> DIV5_SHIFT);
        return s[FSUM_W-1] ? DATA_W'(-$signed({1'b0, q_mag})) : $signed(q_mag);
    endfunction

endpackage

`default_nettype wire

// ===== sv/fsp_filter.sv =====
`default_nettype none

module fsp_filter
    import fsp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] measured,
    input  wire logic signed [DATA_W-1:0] target,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output filt_beat_t                    out_beat
);

    logic signed [DATA_W-1:0] speed_reg;
    logic signed [DATA_W-1:0] speed_next;
    logic                     valid_reg;
    logic                     valid_next;
    filt_beat_t               beat_reg;
    logic                     accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // low-pass recurrence, one divide by five per beat
    always_comb begin
        speed_next = filter_next(speed_reg, measured);
    end

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // filter state and stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                speed_reg <= speed_next;
            end
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            beat_reg.speed  <= speed_next;
            beat_reg.target <= target;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

`default_nettype wire

// ===== sv/fsp_integ.sv =====
`default_nettype none

module fsp_integ
    import fsp_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = 70
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire filt_beat_t  in_beat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output integ_beat_t      out_beat
);

    localparam int INTEG_W = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam logic signed [ACC_W-1:0] LIMIT  = ACC_W'(INTEGRAL_LIMIT);
    localparam logic signed [ACC_W-1:0] DB_HI  = ACC_W'(DEADBAND);
    localparam logic signed [ACC_W-1:0] DB_LO  = -ACC_W'(DEADBAND);

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic                      valid_reg;
    logic                      valid_next;
    integ_beat_t               beat_reg;
    integ_beat_t               beat_next;
    logic                      accept;
    logic signed [ACC_W-1:0]   err;
    logic signed [ACC_W-1:0]   isum;
    logic signed [ACC_W-1:0]   iclamp;
    logic                      dead;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // error, deadband and integral update
    always_comb begin
        err  = ACC_W'(in_beat.speed) - ACC_W'(in_beat.target);
        isum = ACC_W'(in_beat.speed) + ACC_W'(integ_reg);
        dead = (err >= DB_LO) && (err <= DB_HI);
        beat_next.err   = dead ? '0 : err;
        beat_next.integ = dead ? '0 : isum;
        beat_next.speed = in_beat.speed;
        // clamp only after the drive operand is taken
        if (beat_next.integ > LIMIT) begin
            iclamp = LIMIT;
        end else if (beat_next.integ < -LIMIT) begin
            iclamp = -LIMIT;
        end else begin
            iclamp = beat_next.integ;
        end
        beat_next.integ_now = iclamp[INOW_W-1:0];
        integ_next = INTEG_W'(iclamp);
    end

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    // integral state and stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                integ_reg <= integ_next;
            end
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

`ifndef SYNTH
    // stored integral never leaves the clamp window
    a_integ_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (ACC_W'(integ_reg) <= LIMIT) && (ACC_W'(integ_reg) >= -LIMIT))
        else $error("integral state outside limit");

    // zero error only comes from the deadband, which also zeroes the integral
    a_dead_zeroes_integ: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && beat_reg.err == '0) |-> (beat_reg.integ == '0))
        else $error("deadband beat with nonzero integral");

    // a surviving error lies outside the deadband
    a_err_outside_band: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && beat_reg.err != '0)
            |-> ((beat_reg.err > DB_HI) || (beat_reg.err < DB_LO)))
        else $error("error inside deadband passed through");
`endif

endmodule

`default_nettype wire

// ===== sv/fsp_drive.sv =====
`default_nettype none

module fsp_drive
    import fsp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic signed [DATA_W-1:0] kp,
    input  wire logic signed [DATA_W-1:0] ki,
    input  wire logic signed [DATA_W-1:0] out_max,
    input  wire logic signed [DATA_W-1:0] out_min,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire integ_beat_t              in_beat,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output out_beat_t                     out_beat
);

    logic        prod_valid_reg;
    logic        prod_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        prod_ready;
    logic        res_ready;
    logic        prod_accept;
    logic        res_accept;
    prod_beat_t  prod_reg;
    prod_beat_t  prod_next;
    out_beat_t   res_reg;
    out_beat_t   res_next;

    logic signed [SUM_W-1:0] sum;
    logic signed [DRV_W-1:0] shifted;
    logic signed [DRV_W-1:0] hi_clamped;
    logic signed [DRV_W-1:0] lo_clamped;
    logic signed [DRV_W-1:0] max_ext;
    logic signed [DRV_W-1:0] min_ext;

    // ready chain from the result register back
    assign res_ready   = !out_valid_reg || out_ready;
    assign prod_ready  = !prod_valid_reg || res_ready;
    assign in_ready    = prod_ready;
    assign prod_accept = in_valid && prod_ready;
    assign res_accept  = prod_valid_reg && res_ready;

    // gain products
    always_comb begin
        prod_next.prod_p    = PROD_W'(kp) * PROD_W'(in_beat.err);
        prod_next.prod_i    = PROD_W'(ki) * PROD_W'(in_beat.integ);
        prod_next.speed     = in_beat.speed;
        prod_next.integ_now = in_beat.integ_now;
    end

    // pi sum, floor shift by 8, upper then lower clamp
    always_comb begin
        sum        = SUM_W'(prod_reg.prod_p) + SUM_W'(prod_reg.prod_i);
        shifted    = sum[SUM_W-1:8];
        max_ext    = DRV_W'(out_max);
        min_ext    = DRV_W'(out_min);
        hi_clamped = (shifted > max_ext) ? max_ext : shifted;
        lo_clamped = (hi_clamped < min_ext) ? min_ext : hi_clamped;
        res_next.drive     = lo_clamped[DATA_W-1:0];
        res_next.speed     = prod_reg.speed;
        res_next.integ_now = prod_reg.integ_now;
    end

    always_comb begin
        if (prod_accept) begin
            prod_valid_next = 1'b1;
        end else if (res_ready) begin
            prod_valid_next = 1'b0;
        end else begin
            prod_valid_next = prod_valid_reg;
        end
        if (res_accept) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (prod_accept) begin
            prod_reg <= prod_next;
        end
        if (res_accept) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = res_reg;

endmodule

`default_nettype wire

// ===== sv/filtered_speed_pi_loop.sv =====
// channel   | ports                                              | dir
// ----------+----------------------------------------------------+-----
// input     | s_valid s_ready s_measured_speed s_target_speed    | in
// result    | m_valid m_ready m_drive_out m_speed_filtered       | out
//           | m_integral_now                                     |
// config    | cfg_wr_en cfg_index cfg_wdata                      | in
//
// four-stage pipeline: filter, integral, gain products, sum and clamp
// one beat per cycle while the result channel does not stall
// the filter and integral recurrences each close within their own stage
// stalls on m_ready back up stage by stage; bubbles are filled while stalled
// aresetn clears filter state, integral and stage valids; gains go to zero,
// clamps to the full 16-bit range
`default_nettype none

module filtered_speed_pi_loop
    import fsp_pkg::*;
#(
    parameter int INTEGRAL_LIMIT = 70
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [DATA_W-1:0]    s_measured_speed,
    input  wire logic signed [DATA_W-1:0]    s_target_speed,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [DATA_W-1:0]         m_drive_out,
    output logic signed [DATA_W-1:0]         m_speed_filtered,
    output logic signed [INOW_W-1:0]         m_integral_now,
    input  wire logic                        cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [DATA_W-1:0]           cfg_wdata
);

    logic signed [DATA_W-1:0] kp_reg;
    logic signed [DATA_W-1:0] ki_reg;
    logic signed [DATA_W-1:0] out_max_reg;
    logic signed [DATA_W-1:0] out_min_reg;

    logic        filt_valid;
    logic        filt_ready;
    filt_beat_t  filt_beat;
    logic        integ_valid;
    logic        integ_ready;
    integ_beat_t integ_beat;
    out_beat_t   res_beat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            out_max_reg <= 16'sh7FFF;
            out_min_reg <= 16'sh8000;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KP:      kp_reg      <= cfg_wdata;
                REG_KI:      ki_reg      <= cfg_wdata;
                REG_OUT_MAX: out_max_reg <= cfg_wdata;
                REG_OUT_MIN: out_min_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    fsp_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .measured  (s_measured_speed),
        .target    (s_target_speed),
        .out_valid (filt_valid),
        .out_ready (filt_ready),
        .out_beat  (filt_beat)
    );

    fsp_integ #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_integ (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (filt_valid),
        .in_ready  (filt_ready),
        .in_beat   (filt_beat),
        .out_valid (integ_valid),
        .out_ready (integ_ready),
        .out_beat  (integ_beat)
    );

    fsp_drive u_drive (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .kp        (kp_reg),
        .ki        (ki_reg),
        .out_max   (out_max_reg),
        .out_min   (out_min_reg),
        .in_valid  (integ_valid),
        .in_ready  (integ_ready),
        .in_beat   (integ_beat),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_beat  (res_beat)
    );

    assign m_drive_out      = res_beat.drive;
    assign m_speed_filtered = res_beat.speed;
    assign m_integral_now   = res_beat.integ_now;

`ifndef SYNTH
    // input back-pressure only when every stage is full and the output stalls
    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && integ_valid && filt_valid))
        else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire

// ===== dv/filtered_speed_pi_loop_tb.sv =====
`timescale 1ns / 100ps

module filtered_speed_pi_loop_tb;
    import fsp_pkg::*;

    localparam int INTEGRAL_LIMIT = 70;
    localparam int PHASES         = 8;
    localparam int PHASE_TICKS    = 215;

    typedef struct {
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] target;
    } speed_tick_t;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] speed;
        logic signed [INOW_W-1:0] integ;
    } loop_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     s_valid          = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_measured_speed = '0;
    logic signed [DATA_W-1:0] s_target_speed   = '0;
    logic                     m_valid;
    logic                     m_ready          = 1'b0;
    logic signed [DATA_W-1:0] m_drive_out;
    logic signed [DATA_W-1:0] m_speed_filtered;
    logic signed [INOW_W-1:0] m_integral_now;
    logic                     cfg_wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index        = REG_KP;
    logic [DATA_W-1:0]        cfg_wdata        = '0;

    // pending ticks and expected results
    speed_tick_t  tick_pending_q[$];
    loop_result_t tick_results_q[$];

    // controller model state and gain/clamp copy
    int ctl_speed    = 0;
    int ctl_integral = 0;
    int gain_p       = 0;
    int gain_i       = 0;
    int drive_hi     = 32767;
    int drive_lo     = -32768;

    // filter state as seen by the stimulus planner
    int plan_speed = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fault_count    = 0;
    int ticks_sent     = 0;
    int ticks_checked  = 0;
    int deadband_hits  = 0;
    int limit_hits     = 0;
    int crossed_ticks  = 0;
    int settings_run   = 0;

    filtered_speed_pi_loop #(
        .INTEGRAL_LIMIT(INTEGRAL_LIMIT)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_measured_speed(s_measured_speed),
        .s_target_speed  (s_target_speed),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_out     (m_drive_out),
        .m_speed_filtered(m_speed_filtered),
        .m_integral_now  (m_integral_now),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // first-order low-pass, truncating at both divides
    function automatic int lowpass(input int old, input int meas);
        int part;
        part = (old * 3) / 5;
        return (5 * part + 2 * meas) / 5;
    endfunction

    // one control tick of the PI loop
    function automatic loop_result_t pi_tick(input speed_tick_t tick);
        int           err;
        longint       acc;
        longint       drv;
        loop_result_t res;
        ctl_speed    = lowpass(ctl_speed, int'(tick.meas));
        ctl_integral = ctl_integral + ctl_speed;
        err          = ctl_speed - int'(tick.target);
        if (err >= -DEADBAND && err <= DEADBAND) begin
            err          = 0;
            ctl_integral = 0;
            deadband_hits++;
        end
        acc = longint'(gain_p) * longint'(err) + longint'(gain_i) * longint'(ctl_integral);
        drv = acc >>> 8;
        // integral clamp comes after the drive sum
        if (ctl_integral > INTEGRAL_LIMIT) begin
            ctl_integral = INTEGRAL_LIMIT;
            limit_hits++;
        end
        if (ctl_integral < -INTEGRAL_LIMIT) begin
            ctl_integral = -INTEGRAL_LIMIT;
            limit_hits++;
        end
        // upper clamp first, so crossed limits give the lower one
        if (drv > longint'(drive_hi)) begin
            drv = longint'(drive_hi);
        end
        if (drv < longint'(drive_lo)) begin
            drv = longint'(drive_lo);
        end
        if (drive_lo > drive_hi) begin
            crossed_ticks++;
        end
        res.drive = drv[DATA_W-1:0];
        res.speed = ctl_speed[DATA_W-1:0];
        res.integ = ctl_integral[INOW_W-1:0];
        return res;
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                speed_tick_t acc_tick;
                acc_tick.meas   = s_measured_speed;
                acc_tick.target = s_target_speed;
                tick_results_q.push_back(pi_tick(acc_tick));
                ticks_sent++;
            end
            if (!s_valid || s_ready) begin
                if (tick_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    speed_tick_t nxt;
                    nxt = tick_pending_q.pop_front();
                    s_valid          <= 1'b1;
                    s_measured_speed <= nxt.meas;
                    s_target_speed   <= nxt.target;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tick_results_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("%0t: result with nothing expected: drive %0d speed %0d integ %0d",
                             $time, m_drive_out, m_speed_filtered, m_integral_now);
                end
            end else begin
                loop_result_t want;
                want = tick_results_q.pop_front();
                ticks_checked++;
                if (want.drive !== m_drive_out || want.speed !== m_speed_filtered
                        || want.integ !== m_integral_now) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $write("%0t: tick %0d mismatch: drive exp %0d got %0d, ",
                               $time, ticks_checked, want.drive, m_drive_out);
                        $display("speed exp %0d got %0d, integ exp %0d got %0d",
                                 want.speed, m_speed_filtered, want.integ, m_integral_now);
                    end
                end
            end
        end
    end

    // register write, only while the loop is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_KP:      gain_p   = int'(val);
            REG_KI:      gain_i   = int'(val);
            REG_OUT_MAX: drive_hi = int'(val);
            REG_OUT_MIN: drive_lo = int'(val);
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold off until every tick is through the pipeline
    task automatic drain();
        @(negedge aclk);
        while (tick_pending_q.size() > 0 || s_valid || tick_results_q.size() > 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic queue_tick(input int meas, input int target);
        speed_tick_t tick;
        if (target > 32767) begin
            target = 32767;
        end
        if (target < -32768) begin
            target = -32768;
        end
        tick.meas   = meas[DATA_W-1:0];
        tick.target = target[DATA_W-1:0];
        plan_speed  = lowpass(plan_speed, int'(tick.meas));
        tick_pending_q.push_back(tick);
    endtask

    // target placed at a given error from the next filtered speed
    task automatic queue_offset(input int meas, input int err);
        queue_tick(meas, lowpass(plan_speed, meas) - err);
    endtask

    task automatic queue_random(output int added);
        int                       pick;
        int                       meas;
        int                       target;
        int                       run_len;
        logic signed [DATA_W-1:0] raw;
        pick  = $urandom_range(99);
        added = 0;
        if (pick < 15) begin
            // steady run so the integral builds up to its limit
            run_len = $urandom_range(12, 4);
            meas    = int'($urandom_range(60)) - 30;
            target  = int'($urandom_range(200)) - 100;
            repeat (run_len) begin
                queue_tick(meas + int'($urandom_range(4)) - 2, target);
                added++;
            end
        end else begin
            if (pick < 45) begin
                meas = int'($urandom_range(40)) - 20;
            end else if (pick < 70) begin
                meas = int'($urandom_range(4000)) - 2000;
            end else begin
                raw  = DATA_W'($urandom);
                meas = int'(raw);
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                queue_offset(meas, int'($urandom_range(20)) - 10);
            end else if (pick < 65) begin
                queue_offset(meas, int'($urandom_range(600)) - 300);
            end else begin
                raw = DATA_W'($urandom);
                queue_tick(meas, int'(raw));
            end
            added = 1;
        end
    endtask

    task automatic apply_setting(input int idx);
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        a = DATA_W'($urandom);
        b = DATA_W'($urandom);
        case (idx)
            0: begin
                cfg_write(REG_KP, 16'sd256);
                cfg_write(REG_KI, 16'sd64);
                cfg_write(REG_OUT_MAX, 16'sd32767);
                cfg_write(REG_OUT_MIN, -16'sd32768);
            end
            1: begin
                cfg_write(REG_KP, 16'sd32767);
                cfg_write(REG_KI, 16'sd32767);
            end
            2: begin
                cfg_write(REG_KP, -16'sd32768);
                cfg_write(REG_KI, -16'sd32768);
            end
            3: begin
                cfg_write(REG_KP, a);
                cfg_write(REG_KI, b);
                cfg_write(REG_OUT_MAX, 16'sd500);
                cfg_write(REG_OUT_MIN, -16'sd500);
            end
            4: begin
                // crossed window
                cfg_write(REG_KP, 16'sd700);
                cfg_write(REG_KI, -16'sd300);
                cfg_write(REG_OUT_MAX, -16'sd100);
                cfg_write(REG_OUT_MIN, 16'sd100);
            end
            5: begin
                cfg_write(REG_KP, 16'sd0);
                cfg_write(REG_KI, a);
                cfg_write(REG_OUT_MAX, 16'sd0);
                cfg_write(REG_OUT_MIN, 16'sd0);
            end
            6: begin
                cfg_write(REG_KP, a);
                cfg_write(REG_KI, b);
                a = DATA_W'($urandom);
                b = DATA_W'($urandom);
                cfg_write(REG_OUT_MAX, (a > b) ? a : b);
                cfg_write(REG_OUT_MIN, (a > b) ? b : a);
            end
            default: begin
                cfg_write(REG_KP, 16'sd1);
                cfg_write(REG_KI, -16'sd1);
                cfg_write(REG_OUT_MAX, 16'sd32767);
                cfg_write(REG_OUT_MIN, -16'sd32768);
            end
        endcase
        settings_run++;
    endtask

    // stimulus sequence
    initial begin
        int added;
        int count;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset gains and clamps: drive must stay zero
        queue_tick(32767, -32768);
        queue_tick(-32768, 32767);
        queue_tick(0, 0);
        drain();

        cfg_write(REG_KP, 16'sd256);
        cfg_write(REG_KI, 16'sd256);
        cfg_write(REG_OUT_MAX, 16'sd2000);
        cfg_write(REG_OUT_MIN, -16'sd2000);
        settings_run++;
        @(negedge aclk);

        // field extremes, integral pushed past both limits
        repeat (3) queue_tick(32767, 0);
        repeat (3) queue_tick(-32768, 32767);
        queue_tick(-32768, -32768);
        queue_tick(32767, 32767);
        // deadband edges
        queue_offset(100, 6);
        queue_offset(100, -6);
        queue_offset(100, 7);
        queue_offset(100, -7);
        queue_offset(-100, 0);
        // slow negative build-up to the lower integral limit
        repeat (4) queue_tick(-50, 1000);
        repeat (3) queue_tick(40, -1000);
        queue_tick(0, 0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            apply_setting(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            @(negedge aclk);
            count = 0;
            while (count < PHASE_TICKS) begin
                queue_random(added);
                count += added;
            end
            drain();
        end

        repeat (12) @(posedge aclk);
        if (tick_results_q.size() != 0) begin
            fault_count++;
        end
        $display("%0d ticks sent, %0d checked over %0d gain/clamp settings, %0d crossed-window",
                 ticks_sent, ticks_checked, settings_run, crossed_ticks);
        $display("deadband taken %0d times, integral clamped %0d times",
                 deadband_hits, limit_hits);
        if (fault_count == 0) begin
            $display("PASS filtered_speed_pi_loop");
        end else begin
            $display("FAIL filtered_speed_pi_loop");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAIL filtered_speed_pi_loop");
        $finish;
    end

endmodule
